>>> rtl/core/i2crm_pkg.sv
`timescale 1ns / 1ps

package i2crm_pkg;

  // Default bound on the burst length of a read
  localparam int unsigned MAX_READ_BYTES_DEF = 8;

  // Field widths
  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned BIT_IDX_W = 4;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEV_ADDR    = 1'b0,
    REG_HALF_PERIOD = 1'b1
  } cfg_reg_t;

  localparam logic [ADDR_W-1:0] DEV_ADDR_RST    = 8'd60;
  localparam logic [TICK_W-1:0] HALF_PERIOD_RST = 16'd5;

  // Slot of the byte currently shifted out
  typedef enum logic [1:0] {
    SLOT_DEV_WR = 2'd0,
    SLOT_REG    = 2'd1,
    SLOT_DATA   = 2'd2,
    SLOT_DEV_RD = 2'd3
  } byte_slot_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

endpackage

>>> rtl/core/i2c_register_master.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload (low bit first)
// --------  ---  ------------------------  -----------------------------------------
// in_       in   in_tvalid / in_tready     tdata: launch, reg_addr, write_data,
//                                          read_count, sda_in; tuser: operation
// out_      out  out_tvalid / out_tready   tdata: scl_out, sda_out, busy_res,
//                                          read_data, read_valid, ack_bit; tlast: read_last
// cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One input transaction is one tick of the bit sequencer and yields exactly one output
// transaction, computed in the cycle of acceptance and held in the output register.
// Throughput is one tick per clock if results drain; out_tvalid rises in the next cycle.
// A full output register that is not taken stalls input; in_tready stays high while
// the register is empty or being drained in the same cycle.
// rst_n (synchronous, active low) puts the sequencer in idle with both lines released
// and restores the register defaults. cfg_ready is always high.

module i2c_register_master
  import i2crm_pkg::*;
#(
  parameter int unsigned MAX_READ_BYTES = MAX_READ_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // launch[0], reg_addr[8:1], write_data[16:9], read_count[20:17], sda_in[21]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // scl_out[0], sda_out[1], busy_res[2], read_data[10:3], read_valid[11], ack_bit[12]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned BL_W = $clog2(MAX_READ_BYTES + 1);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_HI  = 5'd1,
    PH_ST_LO  = 5'd2,
    PH_BIT_LO = 5'd3,
    PH_BIT_HI = 5'd4,
    PH_ACK_LO = 5'd5,
    PH_ACK_HI = 5'd6,
    PH_RD_LO  = 5'd7,
    PH_RD_HI  = 5'd8,
    PH_MA_LO  = 5'd9,
    PH_MA_HI  = 5'd10,
    PH_SP_A   = 5'd11,
    PH_SP_B   = 5'd12,
    PH_SP_C   = 5'd13,
    PH_RS_A   = 5'd14,
    PH_RS_B   = 5'd15,
    PH_RS_C   = 5'd16
  } phase_t;

  // Input field unpacking
  logic                 launch_i;
  logic                 operation_i;
  logic [ADDR_W-1:0]    reg_addr_i;
  logic [DATA_W-1:0]    write_data_i;
  logic [COUNT_W-1:0]   read_count_i;
  logic                 sda_in_i;

  assign launch_i      = in_tdata[0];
  assign reg_addr_i    = in_tdata[8:1];
  assign write_data_i  = in_tdata[16:9];
  assign read_count_i  = in_tdata[20:17];
  assign sda_in_i      = in_tdata[21];
  assign operation_i   = in_tuser[0];

  // Configuration registers
  logic [ADDR_W-1:0] dev_addr_r;
  logic [TICK_W-1:0] half_period_r;

  // Sequencer state
  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [DATA_W-1:0]   shift_r, shift_nxt;
  logic [BL_W-1:0]     bytes_left_r, bytes_left_nxt;
  logic                held_op_r, held_op_nxt;
  logic [ADDR_W-1:0]   held_reg_r, held_reg_nxt;
  logic [DATA_W-1:0]   held_data_r, held_data_nxt;
  logic                ack_r, ack_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  byte_slot_t          slot_r, slot_nxt;
  logic                mack_r, mack_nxt;

  // Output register
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tlast_r, out_tlast_nxt;
  logic                   out_valid_r;

  logic in_fire;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_valid_r;

  // Segment length; zero behaves as one tick
  logic [TICK_W-1:0] span;
  logic              seg_done;
  assign span     = (half_period_r == '0) ? TICK_W'(1) : half_period_r;
  assign seg_done = ({1'b0, tick_r} + (TICK_W+1)'(1)) >= {1'b0, span};

  always_comb begin
    logic [4:0]        cnt;
    phase_t            ph;
    logic              entered;
    logic              busy;
    logic              scl_now;
    logic              sda_now;
    logic              rd_valid;
    logic              rd_last;
    logic [DATA_W-1:0] rd_data;

    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    held_op_nxt    = held_op_r;
    held_reg_nxt   = held_reg_r;
    held_data_nxt  = held_data_r;
    ack_nxt        = ack_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    slot_nxt       = slot_r;
    mack_nxt       = mack_r;
    entered        = 1'b0;
    busy           = 1'b0;
    rd_valid       = 1'b0;
    rd_last        = 1'b0;
    rd_data        = '0;
    cnt            = {1'b0, read_count_i};

    // Launch is only looked at while idle
    if (phase_r == PH_IDLE && launch_i) begin
      if (cnt == 5'd0) begin
        cnt = 5'd1;
      end
      if (cnt > 5'(MAX_READ_BYTES)) begin
        cnt = 5'(MAX_READ_BYTES);
      end
      held_op_nxt    = operation_i;
      held_reg_nxt   = reg_addr_i;
      held_data_nxt  = write_data_i;
      bytes_left_nxt = BL_W'(cnt);
      slot_nxt       = SLOT_DEV_WR;
      phase_nxt      = PH_ST_HI;
      tick_nxt       = '0;
      scl_nxt        = 1'b1;
      sda_nxt        = 1'b1;
    end

    ph      = phase_nxt;
    scl_now = scl_nxt;
    sda_now = sda_nxt;

    if (ph != PH_IDLE) begin
      busy = 1'b1;
      if (!seg_done) begin
        tick_nxt = tick_nxt + TICK_W'(1);
      end else begin
        entered  = 1'b1;
        tick_nxt = '0;
        case (ph)
          PH_ST_HI: phase_nxt = PH_ST_LO;
          PH_ST_LO: begin
            slot_nxt    = SLOT_DEV_WR;
            shift_nxt   = dev_addr_r;
            bit_idx_nxt = '0;
            phase_nxt   = PH_BIT_LO;
          end
          PH_BIT_LO: phase_nxt = PH_BIT_HI;
          PH_BIT_HI: begin
            shift_nxt   = {shift_r[DATA_W-2:0], 1'b0};
            bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            phase_nxt   = (bit_idx_nxt >= BIT_IDX_W'(DATA_W)) ? PH_ACK_LO : PH_BIT_LO;
          end
          PH_ACK_LO: phase_nxt = PH_ACK_HI;
          PH_ACK_HI: begin
            ack_nxt = sda_in_i;
            case (slot_r)
              SLOT_DEV_WR: begin
                slot_nxt    = SLOT_REG;
                shift_nxt   = held_reg_r;
                bit_idx_nxt = '0;
                phase_nxt   = PH_BIT_LO;
              end
              SLOT_REG: begin
                if (held_op_r == OP_READ) begin
                  phase_nxt = PH_RS_A;
                end else begin
                  slot_nxt    = SLOT_DATA;
                  shift_nxt   = held_data_r;
                  bit_idx_nxt = '0;
                  phase_nxt   = PH_BIT_LO;
                end
              end
              SLOT_DATA: phase_nxt = PH_SP_A;
              default: begin
                bit_idx_nxt = '0;
                shift_nxt   = '0;
                phase_nxt   = PH_RD_LO;
              end
            endcase
          end
          PH_RS_A: phase_nxt = PH_RS_B;
          PH_RS_B: phase_nxt = PH_RS_C;
          PH_RS_C: begin
            slot_nxt    = SLOT_DEV_RD;
            shift_nxt   = dev_addr_r + ADDR_W'(1);
            bit_idx_nxt = '0;
            phase_nxt   = PH_BIT_LO;
          end
          PH_RD_LO: phase_nxt = PH_RD_HI;
          PH_RD_HI: begin
            shift_nxt   = {shift_r[DATA_W-2:0], sda_in_i};
            bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            if (bit_idx_nxt >= BIT_IDX_W'(DATA_W)) begin
              rd_valid  = 1'b1;
              rd_data   = shift_nxt;
              rd_last   = (bytes_left_r <= BL_W'(1));
              mack_nxt  = rd_last;
              phase_nxt = PH_MA_LO;
            end else begin
              phase_nxt = PH_RD_LO;
            end
          end
          PH_MA_LO: phase_nxt = PH_MA_HI;
          PH_MA_HI: begin
            if (bytes_left_r != '0) begin
              bytes_left_nxt = bytes_left_r - BL_W'(1);
            end
            if (bytes_left_nxt == '0) begin
              phase_nxt = PH_SP_A;
            end else begin
              bit_idx_nxt = '0;
              shift_nxt   = '0;
              phase_nxt   = PH_RD_LO;
            end
          end
          PH_SP_A: phase_nxt = PH_SP_B;
          PH_SP_B: phase_nxt = PH_SP_C;
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    // Line levels of the segment just entered
    if (entered) begin
      case (phase_nxt)
        PH_ST_HI: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_ST_LO: begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        PH_BIT_LO: begin scl_nxt = 1'b0; sda_nxt = shift_nxt[DATA_W-1]; end
        PH_BIT_HI: scl_nxt = 1'b1;
        PH_ACK_LO, PH_RD_LO: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_ACK_HI, PH_RD_HI: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_MA_LO: begin scl_nxt = 1'b0; sda_nxt = mack_nxt; end
        PH_MA_HI: begin scl_nxt = 1'b1; sda_nxt = mack_nxt; end
        PH_SP_A: begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        PH_SP_B: begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        PH_RS_A: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        PH_RS_B: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
        PH_RS_C: begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        default: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
      endcase
    end

    out_tdata_nxt = {3'b000, ack_nxt, rd_valid, rd_data, busy, sda_now, scl_now};
    out_tlast_nxt = rd_last;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEV_ADDR_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEV_ADDR:    dev_addr_r    <= cfg_data[ADDR_W-1:0];
        REG_HALF_PERIOD: half_period_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      held_op_r    <= 1'b0;
      held_reg_r   <= '0;
      held_data_r  <= '0;
      ack_r        <= 1'b1;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      slot_r       <= SLOT_DEV_WR;
      mack_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        tick_r       <= tick_nxt;
        bit_idx_r    <= bit_idx_nxt;
        shift_r      <= shift_nxt;
        bytes_left_r <= bytes_left_nxt;
        held_op_r    <= held_op_nxt;
        held_reg_r   <= held_reg_nxt;
        held_data_r  <= held_data_nxt;
        ack_r        <= ack_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        slot_r       <= slot_nxt;
        mack_r       <= mack_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= out_tdata_nxt;
      out_tlast_r <= out_tlast_nxt;
    end
  end

  // Checks
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tlast_r |-> out_tdata_r[11])
    else $error("read_last without read_valid");

  a_read_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[11] |-> out_tdata_r[2])
    else $error("received byte reported while idle");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == '0 && scl_r && sda_r)
    else $error("idle with running tick counter or driven lines");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= BL_W'(MAX_READ_BYTES))
    else $error("burst count beyond limit");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_idx_r <= BIT_IDX_W'(DATA_W))
    else $error("bit index beyond byte");

endmodule

>>> tb/tb_i2c_register_master.sv
`timescale 1ns / 1ps

module tb_i2c_register_master;
  import i2crm_pkg::*;

  localparam int unsigned MAX_RD      = MAX_READ_BYTES_DEF;
  // cycles with no transaction on any channel before the run is declared hung
  localparam int unsigned STALL_LIMIT = 1000;

  // sequencer phases, one per held (SCL, SDA) segment kind
  typedef enum logic [4:0] {
    S_IDLE, S_START_HI, S_START_LO, S_BIT_LO, S_BIT_HI, S_ACK_LO, S_ACK_HI,
    S_RD_LO, S_RD_HI, S_MACK_LO, S_MACK_HI, S_STOP_A, S_STOP_B, S_STOP_C,
    S_RS_A, S_RS_B, S_RS_C
  } seq_phase_t;

  // how the slave side drives SDA over one transaction
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_t;

  // one tick on the input stream
  typedef struct packed {
    logic       launch;
    logic       op;
    logic [7:0] ra;
    logic [7:0] wd;
    logic [3:0] cnt;
    logic       sda;
  } tick_t;

  // one tick on the output stream
  typedef struct packed {
    logic       ack;
    logic       last;
    logic       valid;
    logic [7:0] data;
    logic       busy;
    logic       sda;
    logic       scl;
  } bus_out_t;

  // directed stimulus row: register setting, first tick, slave behavior, optional
  // hand-written result for the first tick
  typedef struct packed {
    logic [15:0] half;
    logic [7:0]  dev;
    tick_t       t;
    sda_mode_t   mode;
    logic        typed;
    bus_out_t    want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;   // launch, reg_addr, write_data, read_count, sda_in
  logic [IN_TUSER_W-1:0]  in_tuser;   // operation
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // scl, sda, busy, read_data, read_valid, ack_bit
  logic                   out_tlast;  // read_last
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predicted sequencer state
  seq_phase_t  m_phase;
  logic [15:0] m_ticks;
  logic [3:0]  m_bit;
  logic [7:0]  m_shift;
  logic [3:0]  m_left;
  logic        m_op;
  logic [7:0]  m_reg;
  logic [7:0]  m_data;
  logic        m_ack;
  logic        m_scl;
  logic        m_sda;
  logic        m_mack;
  byte_slot_t  m_slot;
  // predicted register contents
  logic [7:0]  dev_addr;
  logic [15:0] half_ticks;

  bus_out_t    expected_lines[$];
  plan_row_t   plan[$];

  bit          steady = 1'b0;   // no idling on either side when set
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned ticks_sent = 0;
  int unsigned txn_total = 0;
  int unsigned txn_reads = 0;
  int unsigned bytes_read = 0;
  int unsigned settings = 0;
  int unsigned stuck = 0;

  i2c_register_master #(.MAX_READ_BYTES(MAX_RD)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sequencer prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_sequencer();
    m_phase    = S_IDLE;
    m_ticks    = '0;
    m_bit      = '0;
    m_shift    = '0;
    m_left     = '0;
    m_op       = OP_WRITE;
    m_reg      = '0;
    m_data     = '0;
    m_ack      = 1'b1;
    m_scl      = 1'b1;
    m_sda      = 1'b1;
    m_mack     = 1'b0;
    m_slot     = SLOT_DEV_WR;
    dev_addr   = DEV_ADDR_RST;
    half_ticks = HALF_PERIOD_RST;
  endfunction

  // enter a segment: restart the tick count and set the line levels it holds
  function automatic void go(input seq_phase_t p);
    m_phase = p;
    m_ticks = '0;
    case (p)
      S_START_HI, S_ACK_HI, S_RD_HI,
      S_RS_B, S_STOP_C:         {m_scl, m_sda} = 2'b11;
      S_START_LO, S_STOP_B,
      S_RS_C:                   {m_scl, m_sda} = 2'b10;
      S_ACK_LO, S_RD_LO, S_RS_A: {m_scl, m_sda} = 2'b01;
      S_STOP_A:                 {m_scl, m_sda} = 2'b00;
      S_BIT_LO: begin
        m_scl = 1'b0;
        m_sda = m_shift[7];
      end
      S_BIT_HI:  m_scl = 1'b1;
      S_MACK_LO: {m_scl, m_sda} = {1'b0, m_mack};
      S_MACK_HI: {m_scl, m_sda} = {1'b1, m_mack};
      default: begin
        m_phase = S_IDLE;
        {m_scl, m_sda} = 2'b11;
      end
    endcase
  endfunction

  function automatic void load_byte(input logic [7:0] v, input byte_slot_t s);
    m_slot  = s;
    m_shift = v;
    m_bit   = '0;
    go(S_BIT_LO);
  endfunction

  function automatic void start_rx_byte();
    m_bit   = '0;
    m_shift = '0;
    go(S_RD_LO);
  endfunction

  // one tick of the bit sequencer; returns the line levels and read status it shows
  function automatic bus_out_t advance_sequencer(input tick_t t);
    bus_out_t    r;
    int unsigned span;
    logic [3:0]  n;
    r     = '0;
    r.scl = m_scl;
    r.sda = m_sda;
    span  = (half_ticks == 0) ? 1 : half_ticks;   // zero half period acts as one
    if (m_phase == S_IDLE && t.launch) begin
      m_op   = t.op;
      m_reg  = t.ra;
      m_data = t.wd;
      n = t.cnt;
      if (n == 0) n = 1;                 // zero count still reads one byte
      if (n > MAX_RD) n = 4'(MAX_RD);
      m_left = n;
      m_slot = SLOT_DEV_WR;
      go(S_START_HI);
    end
    if (m_phase != S_IDLE) begin
      r.busy = 1'b1;
      r.scl  = m_scl;
      r.sda  = m_sda;
      if (m_ticks + 1 < span) begin
        m_ticks = m_ticks + 1'b1;
      end else begin
        case (m_phase)
          S_START_HI: go(S_START_LO);
          S_START_LO: load_byte(dev_addr, SLOT_DEV_WR);
          S_BIT_LO:   go(S_BIT_HI);
          S_BIT_HI: begin
            m_shift = {m_shift[6:0], 1'b0};
            m_bit   = m_bit + 1'b1;
            if (m_bit >= 8) go(S_ACK_LO);
            else go(S_BIT_LO);
          end
          S_ACK_LO: go(S_ACK_HI);
          S_ACK_HI: begin
            m_ack = t.sda;   // reported only, never acted on
            if (m_slot == SLOT_DEV_WR) load_byte(m_reg, SLOT_REG);
            else if (m_slot == SLOT_REG) begin
              if (m_op == OP_READ) go(S_RS_A);
              else load_byte(m_data, SLOT_DATA);
            end else if (m_slot == SLOT_DATA) go(S_STOP_A);
            else start_rx_byte();
          end
          S_RS_A: go(S_RS_B);
          S_RS_B: go(S_RS_C);
          S_RS_C: load_byte(dev_addr + 8'd1, SLOT_DEV_RD);   // wraps past 255
          S_RD_LO: go(S_RD_HI);
          S_RD_HI: begin
            m_shift = {m_shift[6:0], t.sda};
            m_bit   = m_bit + 1'b1;
            if (m_bit >= 8) begin
              r.valid = 1'b1;
              r.data  = m_shift;
              r.last  = (m_left <= 1);
              m_mack  = r.last;   // NAK after the final byte
              go(S_MACK_LO);
            end else begin
              go(S_RD_LO);
            end
          end
          S_MACK_LO: go(S_MACK_HI);
          S_MACK_HI: begin
            if (m_left > 0) m_left = m_left - 1'b1;
            if (m_left == 0) go(S_STOP_A);
            else start_rx_byte();
          end
          S_STOP_A: go(S_STOP_B);
          S_STOP_B: go(S_STOP_C);
          default:  go(S_IDLE);
        endcase
      end
    end
    r.ack = m_ack;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic sda_for(input sda_mode_t mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // noise fields; beyond launch and sda, fields matter to the sequencer only on a launch tick
  function automatic tick_t random_tick(input sda_mode_t mode);
    tick_t t;
    t.launch = 1'($urandom_range(0, 1));
    t.op     = 1'($urandom_range(0, 1));
    t.ra     = 8'($urandom_range(0, 255));
    t.wd     = 8'($urandom_range(0, 255));
    t.cnt    = 4'($urandom_range(0, 15));
    t.sda    = sda_for(mode);
    return t;
  endfunction

  function automatic void add_row(input logic [15:0] half, input logic [7:0] dev,
                                  input logic launch, input logic op,
                                  input logic [7:0] ra, input logic [7:0] wd,
                                  input logic [3:0] cnt, input sda_mode_t mode,
                                  input logic typed, input bus_out_t want);
    plan_row_t row;
    row.half  = half;
    row.dev   = dev;
    row.t     = {launch, op, ra, wd, cnt, 1'b0};
    row.mode  = mode;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // one input transaction; the prediction (or a hand-written result) is queued
  task automatic put_tick(input tick_t t, input bit use_typed, input bus_out_t typed_val);
    bus_out_t now_out;
    if (!steady && $urandom_range(0, 15) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tdata  <= {2'b00, t.sda, t.cnt, t.wd, t.ra, t.launch};
    in_tuser  <= t.op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (t.launch && m_phase == S_IDLE) begin
      txn_total++;
      if (t.op == OP_READ) txn_reads++;
    end
    now_out = advance_sequencer(t);
    if (now_out.valid) bytes_read++;
    expected_lines.push_back(use_typed ? typed_val : now_out);
    ticks_sent++;
  endtask

  // first tick, then bus ticks until the sequencer is back in idle
  task automatic run_transaction(input tick_t first, input sda_mode_t mode,
                                 input bit use_typed, input bus_out_t typed_val);
    put_tick(first, use_typed, typed_val);
    while (m_phase != S_IDLE) put_tick(random_tick(mode), 1'b0, '0);
  endtask

  // stop feeding ticks and wait for every outstanding result
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  // only called with the sequencer idle and nothing outstanding
  task automatic program_regs(input logic [7:0] dev, input logic [15:0] half);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEV_ADDR;
    cfg_data  <= {8'h00, dev};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    dev_addr  = dev;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data  <= half;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    half_ticks = half;
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // result side backpressure: random stall bursts, none once steady is set
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 15) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : check_results
    bus_out_t got;
    bus_out_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = {out_tdata[12], out_tlast, out_tdata[11], out_tdata[10:3],
             out_tdata[2], out_tdata[1], out_tdata[0]};
      if (expected_lines.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding: %h",
                                  results_seen, got));
      end else begin
        want = expected_lines.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
            got.data !== want.data || got.valid !== want.valid ||
            got.last !== want.last || got.ack !== want.ack ||
            out_tdata[15:13] !== 3'b000) begin
          report_mismatch($sformatf(
            "result %0d: want scl %b sda %b busy %b data %h valid %b last %b ack %b",
            results_seen, want.scl, want.sda, want.busy, want.data, want.valid,
            want.last, want.ack));
          if (mismatches <= 10)
            $display("           got scl %b sda %b busy %b data %h valid %b last %b ack %b pad %b",
                     got.scl, got.sda, got.busy, got.data, got.valid, got.last,
                     got.ack, out_tdata[15:13]);
        end
      end
      results_seen++;
    end
  end

  // hang detection: any accepted transaction on any channel clears the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) ||
        (cfg_valid && cfg_ready === 1'b1))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[i2c_register_master] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned p;
    int unsigned k;
    tick_t       t;
    sda_mode_t   mode;
    logic [15:0] hp;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DEV_ADDR;
    cfg_data  <= '0;
    clear_sequencer();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows. Hand-written results cover the idle tick after reset, launch
    // ticks whose ack follows from the previous row's constant SDA, and an idle tick
    // at the longest half period. Result layout: ack last valid data busy sda scl.
    //       half   dev  L  op        reg    wdata  cnt    slave SDA  typed
    add_row(16'd5,  8'd60, 1'b0, OP_WRITE, 8'h00, 8'h00, 4'd0,  SDA_HIGH, 1'b1,
            14'b1_0_0_00000000_0_1_1);
    add_row(16'd1,  8'd60, 1'b1, OP_WRITE, 8'h5A, 8'hA5, 4'd1,  SDA_LOW,  1'b1,
            14'b1_0_0_00000000_1_1_1);
    // every ack above was low, and all of these are NAKs; zero half period runs
    // like one tick per segment, the count clamps to the bound and the read
    // address wraps to zero
    add_row(16'd0,  8'd255, 1'b1, OP_READ, 8'hFF, 8'hFF, 4'd15, SDA_HIGH, 1'b1,
            14'b0_0_0_00000000_1_1_1);
    // zero count reads one byte, two ticks per segment
    add_row(16'd2,  8'd254, 1'b1, OP_READ, 8'h7F, 8'h80, 4'd0,  SDA_LOW,  1'b0, '0);
    // longest half period: idle tick only, the previous acks were low
    add_row(16'hFFFF, 8'd254, 1'b0, OP_READ, 8'hFF, 8'hFF, 4'd15, SDA_HIGH, 1'b1,
            14'b0_0_0_00000000_0_1_1);

    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].half != half_ticks || plan[k].dev != dev_addr) begin
        settle();
        program_regs(plan[k].dev, plan[k].half);
      end
      t     = plan[k].t;
      t.sda = sda_for(plan[k].mode);
      run_transaction(t, plan[k].mode, plan[k].typed, plan[k].want);
    end

    // Random part: two register settings, one transaction each after up to two idle
    // ticks; busy ticks carry noise and stray launches. No idling in the last one.
    for (p = 0; p < 2; p++) begin
      settle();
      steady = (p == 1);
      hp = 16'($urandom_range(0, 1));
      program_regs(8'($urandom_range(0, 255)), hp);
      case ($urandom_range(0, 3))
        0:       mode = SDA_LOW;
        1:       mode = SDA_HIGH;
        default: mode = SDA_RAND;
      endcase
      repeat ($urandom_range(0, 2)) begin
        t = random_tick(mode);
        t.launch = 1'b0;
        put_tick(t, 1'b0, '0);
      end
      t = random_tick(mode);
      t.launch = 1'b1;
      t.cnt = 4'($urandom_range(0, 2));
      run_transaction(t, mode, 1'b0, '0);
    end

    settle();
    repeat (4) @(posedge clk);

    $display("ran %0d bus transactions (%0d reads) over %0d register settings, %0d bytes read",
             txn_total, txn_reads, settings, bytes_read);
    $display("%0d ticks driven, %0d results checked, %0d mismatches",
             ticks_sent, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[i2c_register_master] OK");
    end else begin
      $display("[i2c_register_master] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/i2crm_pkg.sv
rtl/core/i2c_register_master.sv
tb/tb_i2c_register_master.sv
